// ----- hdl/sspc_pkg.sv -----
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared widths, codes, state types and helpers for the servo slew and
// pulse-width controller.
// ----------------------------------------------------------------------------
package sspc_pkg;

	// field widths
	localparam int ANG_W   = 9;
	localparam int PULSE_W = 25;
	localparam int SPEED_W = 16;
	localparam int TICK_W  = 10;
	localparam int OP_W    = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = PULSE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 3'd5;

	// stream widths
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = OP_W;
	localparam int OUT_W     = 1 + 1 + PULSE_W + ANG_W + ANG_W + 1 + 1;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_SET     = 2'd1;
	localparam logic [OP_W-1:0] OP_ENABLE  = 2'd2;
	localparam logic [OP_W-1:0] OP_DISABLE = 2'd3;

	// reset values
	localparam logic [ANG_W-1:0]   RST_MIN_ANGLE   = 9'd0;
	localparam logic [ANG_W-1:0]   RST_MAX_ANGLE   = 9'd180;
	localparam logic [PULSE_W-1:0] RST_MIN_PULSE   = 25'd1000000;
	localparam logic [PULSE_W-1:0] RST_MAX_PULSE   = 25'd2000000;
	localparam logic [SPEED_W-1:0] RST_SPEED       = 16'd0;
	localparam logic [TICK_W-1:0]  RST_TICK_PERIOD = 10'd20;
	localparam logic [ANG_W-1:0]   RST_ANGLE       = 9'd90;

	// serial multiply-divide unit: (a * b + addend) / divisor
	localparam int MD_A_W   = PULSE_W;
	localparam int MD_B_W   = TICK_W;
	localparam int MD_D_W   = 10;
	localparam int MD_N_W   = MD_A_W + MD_B_W;
	localparam int MD_Q_W   = PULSE_W;
	localparam int MD_CNT_W = $clog2(MD_Q_W);

	// step rounding: (speed * tick + 500) / 1000
	localparam logic [MD_D_W-1:0] STEP_ROUND = 10'd500;
	localparam logic [MD_D_W-1:0] STEP_DIV   = 10'd1000;

	typedef struct packed {
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [MD_D_W-1:0] addend;
		logic [MD_D_W-1:0] divisor;
	} sspc_mdop_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} sspc_mdphase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_STEP,
		ST_APPLY,
		ST_PULSE,
		ST_DONE
	} sspc_state_t;

	// raise to the lower limit first, then lower to the upper limit
	function automatic logic [ANG_W-1:0] clamp_angle(
		input logic [ANG_W-1:0] v,
		input logic [ANG_W-1:0] lo,
		input logic [ANG_W-1:0] hi
	);
		logic [ANG_W-1:0] r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

endpackage

// ----- hdl/servo_slew_pwm_controller.sv -----
// Path, input transfer to m_tvalid: ST_DECODE then ST_DONE for an item with no computation;
// ST_APPLY between them when a pulse is refused for invalid limits; ST_APPLY and ST_PULSE for
// a pulse update; ST_STEP, ST_APPLY and, unless its pulse is refused, ST_PULSE for a tick
// that moves the servo (serial multiply-divide in ST_STEP and ST_PULSE). Throughput: one item
// in work at a time; s_tready rises with m_tvalid, later while the result awaits m_tready.
// Reset (arst_n low) restores register defaults, output off, both angles 90; no clearing pass.
// ----------------------------------------------------------------------------
// servo_slew_pwm_controller
// Servo position controller with slew-rate limited ticks and linear
// angle-to-pulse-width mapping, one result per input transfer.
// ----------------------------------------------------------------------------
module servo_slew_pwm_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [sspc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sspc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sspc_pkg::S_TDATA_W-1:0]    s_tdata,  // angle[8:0]
	input  logic [sspc_pkg::S_TUSER_W-1:0]    s_tuser,  // operation[1:0]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// output_on[0], pulse_update[1], pulse_width[26:2], current_angle_out[35:27],
	// target_angle_out[44:36], moving[45], limits_invalid[46]
	output logic [sspc_pkg::M_TDATA_W-1:0]    m_tdata
);
	import sspc_pkg::*;

	// configuration registers
	logic [ANG_W-1:0]   min_angle_q, max_angle_q;
	logic [PULSE_W-1:0] min_pulse_q, max_pulse_q;
	logic [SPEED_W-1:0] speed_q;
	logic [TICK_W-1:0]  tick_period_q;

	// controller state
	sspc_state_t        state_q, state_d;
	logic               en_q;
	logic [ANG_W-1:0]   cur_q, tgt_q;
	logic [PULSE_W-1:0] last_pulse_q;
	logic               upd_q;
	logic               m_tvalid_q;

	// item payload
	logic [OP_W-1:0]    op_q;
	logic [ANG_W-1:0]   req_q;
	logic [ANG_W-1:0]   app_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// combinational helpers
	logic               limits_bad;
	logic               move_ok;
	logic [ANG_W-1:0]   req_clamped;
	logic [ANG_W-1:0]   app_clamped;
	logic [MD_Q_W-1:0]  step;
	logic               tgt_above;
	logic [ANG_W-1:0]   gap_ang;
	logic [ANG_W-1:0]   move;
	logic [ANG_W-1:0]   step_angle;
	logic               out_free;
	logic               out_load;
	logic               md_start;
	logic               md_done;
	logic [MD_Q_W-1:0]  md_quot;
	sspc_mdop_t         md_op;

	// limit checks, clamps and step arithmetic
	always_comb begin
		limits_bad  = (max_angle_q <= min_angle_q) || (max_pulse_q <= min_pulse_q);
		move_ok     = en_q && (speed_q != '0) && (cur_q != tgt_q);
		req_clamped = clamp_angle(req_q, min_angle_q, max_angle_q);
		app_clamped = clamp_angle(app_q, min_angle_q, max_angle_q);
		step        = (md_quot == '0) ? MD_Q_W'(1) : md_quot;
		tgt_above   = (tgt_q > cur_q);
		gap_ang     = tgt_above ? (tgt_q - cur_q) : (cur_q - tgt_q);
		move        = (step < MD_Q_W'(gap_ang)) ? step[ANG_W-1:0] : gap_ang;
		step_angle  = tgt_above ? (cur_q + move) : (cur_q - move);
	end

	// operands for the shared serial unit
	always_comb begin
		if (state_q == ST_DECODE) begin
			md_op.a       = MD_A_W'(speed_q);
			md_op.b       = MD_B_W'(tick_period_q);
			md_op.addend  = STEP_ROUND;
			md_op.divisor = STEP_DIV;
		end else begin
			md_op.a       = max_pulse_q - min_pulse_q;
			md_op.b       = MD_B_W'(app_clamped - min_angle_q);
			md_op.addend  = '0;
			md_op.divisor = MD_D_W'(max_angle_q - min_angle_q);
		end
	end

	// next state and handshake control
	always_comb begin
		state_d  = state_q;
		md_start = 1'b0;
		out_free = !m_tvalid_q || m_tready;
		out_load = 1'b0;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (op_q)
					OP_TICK: begin
						if (move_ok) begin
							md_start = 1'b1;
							state_d  = ST_STEP;
						end else begin
							state_d = ST_DONE;
						end
					end
					OP_SET:    state_d = (en_q && speed_q == '0) ? ST_APPLY : ST_DONE;
					OP_ENABLE: state_d = en_q ? ST_DONE : ST_APPLY;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_STEP: begin
				if (md_done) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (en_q && !limits_bad) begin
					md_start = 1'b1;
					state_d  = ST_PULSE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PULSE: begin
				if (md_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register, configuration and servo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			min_angle_q   <= RST_MIN_ANGLE;
			max_angle_q   <= RST_MAX_ANGLE;
			min_pulse_q   <= RST_MIN_PULSE;
			max_pulse_q   <= RST_MAX_PULSE;
			speed_q       <= RST_SPEED;
			tick_period_q <= RST_TICK_PERIOD;
			en_q          <= 1'b0;
			cur_q         <= RST_ANGLE;
			tgt_q         <= RST_ANGLE;
			last_pulse_q  <= RST_MIN_PULSE;
			upd_q         <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_ANGLE:   min_angle_q   <= cfg_data[ANG_W-1:0];
					CFG_MAX_ANGLE:   max_angle_q   <= cfg_data[ANG_W-1:0];
					CFG_MIN_PULSE:   min_pulse_q   <= cfg_data[PULSE_W-1:0];
					CFG_MAX_PULSE:   max_pulse_q   <= cfg_data[PULSE_W-1:0];
					CFG_SPEED:       speed_q       <= cfg_data[SPEED_W-1:0];
					CFG_TICK_PERIOD: tick_period_q <= cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) upd_q <= 1'b0;
				end
				ST_DECODE: begin
					case (op_q)
						OP_SET:     tgt_q <= req_clamped;
						OP_ENABLE:  en_q  <= 1'b1;
						OP_DISABLE: en_q  <= 1'b0;
						default: ;
					endcase
				end
				ST_PULSE: begin
					if (md_done) begin
						last_pulse_q <= min_pulse_q + md_quot;
						cur_q        <= app_q;
						upd_q        <= 1'b1;
					end
				end
				default: ;
			endcase
			// output register
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser[OP_W-1:0];
			req_q <= s_tdata[ANG_W-1:0];
		end
		if (state_q == ST_DECODE) begin
			// apply target on a jump, the held angle on enable
			app_q <= (op_q == OP_SET) ? req_clamped : cur_q;
		end
		if (state_q == ST_STEP && md_done) app_q <= step_angle;
		if (out_load) begin
			m_tdata_q <= {{(M_TDATA_W - OUT_W){1'b0}}, limits_bad, move_ok, tgt_q, cur_q,
				last_pulse_q, upd_q, en_q};
		end
	end

	sspc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.op     (md_op),
		.done   (md_done),
		.quot   (md_quot)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	// the serial unit only finishes while a computation is awaited
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == ST_STEP || state_q == ST_PULSE))
		else $error("muldiv done outside a wait state");

	// a result with a pulse update is only loaded while enabled
	a_update_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && upd_q |-> en_q)
		else $error("pulse update reported while disabled");

	// a finished item reaches the output register in the cycle after room opens
	a_done_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !m_tvalid_q |=> m_tvalid_q && state_q == ST_IDLE)
		else $error("finished item not loaded into output register");
`endif

endmodule

// ----- hdl/sspc_muldiv.sv -----
// ----------------------------------------------------------------------------
// sspc_muldiv
// Bit-serial unit computing (a * b + addend) / divisor: shift-add multiply
// one multiplier bit per cycle, then restoring division one quotient bit per
// cycle. The caller guarantees the quotient fits in MD_Q_W bits.
// ----------------------------------------------------------------------------
module sspc_muldiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  sspc_pkg::sspc_mdop_t          op,
	output logic                          done,
	output logic [sspc_pkg::MD_Q_W-1:0]   quot
);
	import sspc_pkg::*;

	sspc_mdphase_t phase_q, phase_d;
	logic [MD_CNT_W-1:0] cnt_q;
	logic                done_q;
	logic [MD_N_W-1:0]   mcand_q;
	logic [MD_B_W-1:0]   mplier_q;
	logic [MD_N_W-1:0]   acc_q;
	logic [MD_D_W-1:0]   rem_q;
	logic [MD_D_W-1:0]   div_q;
	logic [MD_Q_W-1:0]   quot_q;

	logic [MD_N_W-1:0]   acc_sum;
	logic [MD_D_W:0]     trial;
	logic [MD_D_W:0]     trial_sub;
	logic                qbit;
	logic [MD_D_W-1:0]   rem_next;
	logic                mul_last;
	logic                div_last;

	// one partial product add and one trial subtract per cycle
	always_comb begin
		acc_sum   = acc_q + (mplier_q[0] ? mcand_q : '0);
		trial     = {rem_q, acc_q[MD_Q_W-1]};
		trial_sub = trial - {1'b0, div_q};
		qbit      = (trial >= {1'b0, div_q});
		rem_next  = qbit ? trial_sub[MD_D_W-1:0] : trial[MD_D_W-1:0];
		mul_last  = (cnt_q == MD_CNT_W'(MD_B_W - 1));
		div_last  = (cnt_q == MD_CNT_W'(MD_Q_W - 1));
	end

	// phase sequencing
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			MD_IDLE: if (start) phase_d = MD_MUL;
			MD_MUL:  if (mul_last) phase_d = MD_DIV;
			MD_DIV:  if (div_last) phase_d = MD_IDLE;
			default: phase_d = MD_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == MD_DIV) && div_last;
			if (phase_q != phase_d) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + MD_CNT_W'(1);
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		case (phase_q)
			MD_IDLE: begin
				if (start) begin
					mcand_q  <= MD_N_W'(op.a);
					mplier_q <= op.b;
					acc_q    <= MD_N_W'(op.addend);
					div_q    <= op.divisor;
				end
			end
			MD_MUL: begin
				mcand_q  <= {mcand_q[MD_N_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[MD_B_W-1:1]};
				acc_q    <= acc_sum;
				// upper bits stay below the divisor, so they seed the remainder
				if (mul_last) rem_q <= acc_sum[MD_N_W-1:MD_Q_W];
			end
			MD_DIV: begin
				acc_q  <= {acc_q[MD_N_W-2:0], 1'b0};
				rem_q  <= rem_next;
				quot_q <= {quot_q[MD_Q_W-2:0], qbit};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
